// File: rtl/core/tfr_pkg.sv
// shared types, constants and helpers for the telemetry frame receiver
`default_nettype none

package tfr_pkg;

  localparam int WORDS_DEF = 15;

  localparam logic [7:0]  SYNC_CHAR_RST  = 8'd65;
  localparam logic [30:0] LIMIT_BITS_RST = 31'd1232348144;
  localparam logic [31:0] ONE_BITS       = 32'h3F80_0000;

  localparam int QUAT_WORDS = 4;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_CHAR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_BITS = 2'd1;

  typedef enum logic [1:0] {
    PH_HUNT_FIRST  = 2'd0,
    PH_HUNT_SECOND = 2'd1,
    PH_BODY        = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ST_LOAD  = 2'd0,
    ST_CHECK = 2'd1,
    ST_EMIT  = 2'd2
  } state_t;

  function automatic logic is_bad(input logic [31:0] word, input logic [30:0] limit);
    return word[30:0] > limit;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/tfr_ram.sv
// generic single-write, single-read synchronous ram with registered read data
`default_nettype none

module tfr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/telemetry_frame_receiver.sv
// telemetry frame receiver top level: sync hunt, word store and frame readout
//
// Bytes are taken one per cycle while the block hunts for the two sync
// characters and while it loads the frame body; every fourth body byte
// completes a word that is written to the word ram. After the byte that completes
// the last word, in_stall stays high until readout is done: the single
// ram read port first reads words 0 to 3 to judge the quaternion, then reads
// all WORDS words, one per cycle, into the output register, which slows down
// with out_stall. The limit is applied at readout time.
`default_nettype none

module telemetry_frame_receiver #(
  parameter int WORDS = tfr_pkg::WORDS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,

  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [7:0]                    in_rx_byte,

  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [5:0]                    out_word_index,
  output logic      [31:0]                   out_word_value,
  output logic                               out_replaced,
  output logic                               out_last,

  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [tfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                   cfg_data
);

  import tfr_pkg::*;

  localparam int AW = $clog2(WORDS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(WORDS - 1);
  localparam logic [AW-1:0] QUAT_LAST = AW'(QUAT_WORDS - 1);

  logic [7:0]  sync_char_r;
  logic [30:0] limit_bits_r;

  state_t      state_r,    state_nxt;
  phase_t      phase_r,    phase_nxt;
  logic [1:0]  byte_cnt_r, byte_cnt_nxt;
  logic [AW-1:0] wcnt_r,   wcnt_nxt;
  logic [23:0] shift_r,    shift_nxt;

  logic [AW-1:0] rd_addr_r, rd_addr_nxt;
  logic        issuing_r,  issuing_nxt;
  logic        pend_r,     pend_nxt;
  logic [AW-1:0] pend_idx_r, pend_idx_nxt;
  logic        qbad_r,     qbad_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [5:0]  out_index_r, out_index_nxt;
  logic [31:0] out_value_r, out_value_nxt;
  logic        out_rep_r,   out_rep_nxt;
  logic        out_last_r,  out_last_nxt;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [31:0]   wr_data;
  logic          rd_en;
  logic [31:0]   rd_data;

  logic          in_xfer;
  logic          move;
  logic          consume;
  logic          word_bad;
  logic [AW-1:0] last_addr;

  tfr_ram #(
    .WIDTH (32),
    .DEPTH (WORDS)
  ) u_word_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr_r),
    .rd_data (rd_data)
  );

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_char_r  <= SYNC_CHAR_RST;
      limit_bits_r <= LIMIT_BITS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SYNC_CHAR:  sync_char_r  <= cfg_data[7:0];
        CFG_LIMIT_BITS: limit_bits_r <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    byte_cnt_nxt  = byte_cnt_r;
    wcnt_nxt      = wcnt_r;
    shift_nxt     = shift_r;
    rd_addr_nxt   = rd_addr_r;
    issuing_nxt   = issuing_r;
    pend_idx_nxt  = pend_idx_r;
    qbad_nxt      = qbad_r;
    out_index_nxt = out_index_r;
    out_value_nxt = out_value_r;
    out_rep_nxt   = out_rep_r;
    out_last_nxt  = out_last_r;

    in_stall = (state_r != ST_LOAD);
    in_xfer  = in_valid && !in_stall;
    wr_en    = 1'b0;
    wr_addr  = wcnt_r;
    wr_data  = {shift_r, in_rx_byte};

    word_bad  = is_bad(rd_data, limit_bits_r);
    last_addr = (state_r == ST_CHECK) ? QUAT_LAST : LAST_ADDR;
    move      = (state_r == ST_EMIT) && pend_r && (!out_valid_r || !out_stall);
    consume   = (state_r == ST_CHECK) ? pend_r : move;
    rd_en     = issuing_r && (!pend_r || consume);

    if (rd_en) begin
      pend_idx_nxt = rd_addr_r;
      if (rd_addr_r == last_addr) begin
        issuing_nxt = 1'b0;
      end else begin
        rd_addr_nxt = rd_addr_r + 1'b1;
      end
    end
    pend_nxt = rd_en || (pend_r && !consume);

    unique case (state_r)
      ST_LOAD: begin
        if (in_xfer) begin
          unique case (phase_r)
            PH_HUNT_SECOND: begin
              if (in_rx_byte == sync_char_r) begin
                phase_nxt    = PH_BODY;
                byte_cnt_nxt = 2'd0;
              end else begin
                phase_nxt = PH_HUNT_FIRST;
              end
            end
            PH_BODY: begin
              shift_nxt    = {shift_r[15:0], in_rx_byte};
              byte_cnt_nxt = byte_cnt_r + 2'd1;
              if (byte_cnt_r == 2'd3) begin
                wr_en = 1'b1;
                if (wcnt_r == LAST_ADDR) begin
                  wcnt_nxt    = '0;
                  phase_nxt   = PH_HUNT_FIRST;
                  state_nxt   = ST_CHECK;
                  rd_addr_nxt = '0;
                  issuing_nxt = 1'b1;
                  qbad_nxt    = 1'b0;
                end else begin
                  wcnt_nxt = wcnt_r + 1'b1;
                end
              end
            end
            default: begin
              wcnt_nxt  = '0;
              phase_nxt = (in_rx_byte == sync_char_r) ? PH_HUNT_SECOND : PH_HUNT_FIRST;
            end
          endcase
        end
      end
      ST_CHECK: begin
        if (consume) begin
          qbad_nxt = qbad_r || word_bad;
          if (pend_idx_r == QUAT_LAST) begin
            state_nxt   = ST_EMIT;
            rd_addr_nxt = '0;
            issuing_nxt = 1'b1;
          end
        end
      end
      ST_EMIT: begin
        if (move) begin
          out_index_nxt = 6'(pend_idx_r);
          out_last_nxt  = (pend_idx_r == LAST_ADDR);
          if (pend_idx_r <= QUAT_LAST) begin
            out_rep_nxt   = qbad_r;
            out_value_nxt = !qbad_r ? rd_data : ((pend_idx_r == '0) ? ONE_BITS : '0);
          end else begin
            out_rep_nxt   = word_bad;
            out_value_nxt = word_bad ? '0 : rd_data;
          end
          if (pend_idx_r == LAST_ADDR) begin
            state_nxt = ST_LOAD;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase

    out_valid_nxt = move || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      phase_r     <= PH_HUNT_FIRST;
      byte_cnt_r  <= '0;
      wcnt_r      <= '0;
      rd_addr_r   <= '0;
      issuing_r   <= 1'b0;
      pend_r      <= 1'b0;
      qbad_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      byte_cnt_r  <= byte_cnt_nxt;
      wcnt_r      <= wcnt_nxt;
      rd_addr_r   <= rd_addr_nxt;
      issuing_r   <= issuing_nxt;
      pend_r      <= pend_nxt;
      qbad_r      <= qbad_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shift_r     <= shift_nxt;
    pend_idx_r  <= pend_idx_nxt;
    out_index_r <= out_index_nxt;
    out_value_r <= out_value_nxt;
    out_rep_r   <= out_rep_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_word_index = out_index_r;
  assign out_word_value = out_value_r;
  assign out_replaced   = out_rep_r;
  assign out_last       = out_last_r;

`ifndef SYNTHESIS
  a_no_pend_in_load: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_LOAD |-> !pend_r)
    else $error("read data pending while loading");

  a_frame_end_check: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en && wcnt_r == LAST_ADDR |=> state_r == ST_CHECK)
    else $error("last word written without quaternion check");

  a_check_reads_quat: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CHECK && rd_en |-> rd_addr_r <= QUAT_LAST)
    else $error("quaternion check reads past word 3");

  a_replaced_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_replaced && out_word_index != 6'd0 |-> out_word_value == 32'd0)
    else $error("replaced word other than word 0 is not zero");

  a_no_write_in_readout: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_LOAD |-> !wr_en)
    else $error("word ram written during readout");
`endif

endmodule

`default_nettype wire
